// ----- hw/rtl/x87rs_pkg.sv -----
package x87rs_pkg;

   typedef enum logic [2:0] {
      KIND_LOAD      = 3'd0,
      KIND_STORE_POP = 3'd1,
      KIND_PUSH_ONE  = 3'd2,
      KIND_PUSH_ZERO = 3'd3,
      KIND_COPY_POP  = 3'd4,
      KIND_INIT      = 3'd5
   } kind_type;

   localparam logic [1:0]  TAG_VALID = 2'd0;
   localparam logic [1:0]  TAG_ZERO  = 2'd1;
   localparam logic [1:0]  TAG_EMPTY = 2'd3;

   localparam logic [15:0] TAG_WORD_RESET = 16'hFFFF;
   localparam logic [63:0] MANT_ONE       = 64'h8000_0000_0000_0000;
   localparam logic [15:0] SE_ONE         = 16'h3FFF;
   localparam logic [14:0] EXP_EXT_MAX    = 15'h7FFF;
   localparam logic [22:0] QNAN_BIT       = 23'h40_0000;
   // extended bias minus single bias
   localparam logic [14:0] BIAS_DIFF      = 15'd16256;
   // smallest extended exponent that overflows single precision
   localparam logic [14:0] EXP_OVF_MIN    = 15'd16511;

   typedef struct packed {
      logic [15:0] se;
      logic [63:0] mant;
   } freg_type;

   function automatic freg_type widen(input logic [31:0] f);
      freg_type   r;
      logic       s;
      logic [7:0] e;
      logic [22:0] fr;
      s  = f[31];
      e  = f[30:23];
      fr = f[22:0];
      if (e == 8'd0 && fr == 23'd0) begin
         r.se   = {s, 15'd0};
         r.mant = 64'd0;
      end else if (e == 8'hFF) begin
         r.se   = {s, EXP_EXT_MAX};
         r.mant = (fr == 23'd0) ? MANT_ONE : {1'b0, fr | QNAN_BIT, 40'd0};
      end else begin
         r.se   = {s, {7'd0, e} + BIAS_DIFF};
         r.mant = {1'b1, fr, 40'd0};
      end
      return r;
   endfunction

   // truncating conversion to single precision
   function automatic logic [31:0] narrow(input freg_type r);
      logic        s;
      logic [14:0] e;
      logic [14:0] eb;
      logic [31:0] res;
      s  = r.se[15];
      e  = r.se[14:0];
      eb = e - BIAS_DIFF;
      if (e <= BIAS_DIFF) begin
         res = {s, 31'd0};
      end else if (e >= EXP_OVF_MIN) begin
         res = {s, 8'hFF, 23'd0};
      end else begin
         res = {s, eb[7:0], r.mant[62:40]};
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/x87_register_stack_subset_top.sv -----
// Eight-entry x87 register stack subset. Each item is one stack instruction and
// gives exactly one result item carrying the new top pointer and tag word, plus
// the narrowed single-precision value and address for a store-and-pop. The
// register contents live in a synchronous register file with a registered read:
// the top entry is read when an item is taken, and the execute state then
// converts, writes back and updates top and tags. No new item is taken while
// one is in the execute state. A finished result waits in the output register
// without blocking the next item from being taken; that item then waits in the
// execute stage until the output register frees up. Init resets top and tags
// only, the register contents stay.
module x87_register_stack_subset_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [2:0]  req_reg_index,
   input  logic [31:0] req_load_data,
   input  logic [19:0] req_mem_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_store_valid,
   output logic [19:0] rsp_store_address,
   output logic [31:0] rsp_store_data,
   output logic [2:0]  rsp_stack_top,
   output logic [15:0] rsp_tag_bits
);
   import x87rs_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type   state_ff;
   logic [2:0]  top_ff, top_in;
   logic [15:0] tag_ff, tag_in;

   kind_type    kind_ff;
   logic [2:0]  idx_ff;
   logic [31:0] data_ff;
   logic [19:0] addr_ff;

   logic [63:0] mant_mem [8];
   logic [15:0] se_mem   [8];
   freg_type    rd_ff;

   logic        rsp_valid_ff;
   logic        rsp_store_valid_ff, rsp_store_valid_in;
   logic [19:0] rsp_store_address_ff, rsp_store_address_in;
   logic [31:0] rsp_store_data_ff, rsp_store_data_in;

   logic        accept;
   logic        done;
   logic        wr_en;
   logic [2:0]  wr_addr;
   freg_type    wr_data;
   freg_type    ld_reg;
   logic [1:0]  ld_tag;
   logic [2:0]  push_top;
   logic [2:0]  pop_top;
   logic [2:0]  dst;

   assign req_stall = (state_ff == ST_EXEC);
   assign accept    = req_valid && !req_stall;
   assign done      = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign ld_reg   = widen(data_ff);
   assign ld_tag   = (ld_reg.mant == 64'd0 && ld_reg.se[14:0] == 15'd0) ? TAG_ZERO : TAG_VALID;
   assign push_top = top_ff - 3'd1;
   assign pop_top  = top_ff + 3'd1;
   assign dst      = top_ff + idx_ff;

   always_comb begin
      top_in               = top_ff;
      tag_in               = tag_ff;
      wr_en                = 1'b0;
      wr_addr              = push_top;
      wr_data              = ld_reg;
      rsp_store_valid_in   = 1'b0;
      rsp_store_address_in = 20'd0;
      rsp_store_data_in    = 32'd0;
      case (kind_ff)
         KIND_LOAD: begin
            top_in                       = push_top;
            wr_en                        = 1'b1;
            tag_in[{push_top, 1'b0} +: 2] = ld_tag;
         end
         KIND_STORE_POP: begin
            rsp_store_valid_in          = 1'b1;
            rsp_store_address_in        = addr_ff;
            rsp_store_data_in           = narrow(rd_ff);
            tag_in[{top_ff, 1'b0} +: 2] = TAG_EMPTY;
            top_in                      = pop_top;
         end
         KIND_PUSH_ONE: begin
            top_in                        = push_top;
            wr_en                         = 1'b1;
            wr_data.se                    = SE_ONE;
            wr_data.mant                  = MANT_ONE;
            tag_in[{push_top, 1'b0} +: 2] = TAG_VALID;
         end
         KIND_PUSH_ZERO: begin
            top_in                        = push_top;
            wr_en                         = 1'b1;
            wr_data.se                    = 16'd0;
            wr_data.mant                  = 64'd0;
            tag_in[{push_top, 1'b0} +: 2] = TAG_ZERO;
         end
         KIND_COPY_POP: begin
            wr_en                       = 1'b1;
            wr_addr                     = dst;
            wr_data                     = rd_ff;
            tag_in[{dst, 1'b0} +: 2]    = tag_ff[{top_ff, 1'b0} +: 2];
            // pop last so a copy onto itself still leaves the top empty
            tag_in[{top_ff, 1'b0} +: 2] = TAG_EMPTY;
            top_in                      = pop_top;
         end
         KIND_INIT: begin
            top_in = 3'd0;
            tag_in = TAG_WORD_RESET;
         end
         default: begin
         end
      endcase
   end

   // register file: read the top when an item is taken, write back on completion
   always_ff @(posedge clock) begin
      if (done && wr_en) begin
         mant_mem[wr_addr] <= wr_data.mant;
         se_mem[wr_addr]   <= wr_data.se;
      end
      if (accept) begin
         rd_ff.mant <= mant_mem[top_ff];
         rd_ff.se   <= se_mem[top_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_type'(req_kind);
         idx_ff  <= req_reg_index;
         data_ff <= req_load_data;
         addr_ff <= req_mem_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_ff       <= 3'd0;
         tag_ff       <= TAG_WORD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result replaces one that leaves on the same edge
         rsp_valid_ff <= done || (rsp_valid_ff && rsp_stall);
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (done) begin
                  state_ff             <= ST_IDLE;
                  top_ff               <= top_in;
                  tag_ff               <= tag_in;
                  rsp_store_valid_ff   <= rsp_store_valid_in;
                  rsp_store_address_ff <= rsp_store_address_in;
                  rsp_store_data_ff    <= rsp_store_data_in;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_store_valid   = rsp_store_valid_ff;
   assign rsp_store_address = rsp_store_address_ff;
   assign rsp_store_data    = rsp_store_data_ff;
   assign rsp_stack_top     = top_ff;
   assign rsp_tag_bits      = tag_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("taken item did not enter execute");

   a_result_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result appeared without an executed item");

   a_store_pops_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_store_valid_ff |->
         tag_ff[{top_ff - 3'd1, 1'b0} +: 2] == TAG_EMPTY)
      else $error("store-and-pop left the old top tagged in use");

endmodule

// ----- tb/tb_x87_register_stack_subset_top.sv -----
`timescale 1ns / 100ps
module tb_x87_register_stack_subset_top;
   import x87rs_pkg::*;

   localparam logic [2:0] KIND_RSVD_6 = 3'd6;
   localparam logic [2:0] KIND_RSVD_7 = 3'd7;
   localparam int RANDOM_ITEMS = 1620;
   localparam int IDLE_PCT     = 32;
   localparam int CALM_FIRST   = 900;
   localparam int CALM_LAST    = 1200;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_LIMIT  = 5000;

   typedef struct {
      logic [2:0]  kind;
      logic [2:0]  reg_index;
      logic [31:0] load_data;
      logic [19:0] mem_address;
   } fpu_instr_type;

   typedef struct {
      logic        store_valid;
      logic [19:0] store_address;
      logic [31:0] store_data;
      logic [2:0]  stack_top;
      logic [15:0] tag_bits;
   } stack_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = KIND_INIT;
   logic [2:0]  req_reg_index = 3'd0;
   logic [31:0] req_load_data = 32'd0;
   logic [19:0] req_mem_address = 20'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_store_valid;
   logic [19:0] rsp_store_address;
   logic [31:0] rsp_store_data;
   logic [2:0]  rsp_stack_top;
   logic [15:0] rsp_tag_bits;

   x87_register_stack_subset_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_reg_index     (req_reg_index),
      .req_load_data     (req_load_data),
      .req_mem_address   (req_mem_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_store_valid   (rsp_store_valid),
      .rsp_store_address (rsp_store_address),
      .rsp_store_data    (rsp_store_data),
      .rsp_stack_top     (rsp_stack_top),
      .rsp_tag_bits      (rsp_tag_bits)
   );

   always #10 clock = ~clock;

   // stack shadow used to compute expected results
   logic [63:0] fpr_mant [8];
   logic [15:0] fpr_se [8];
   logic [2:0]  fpr_top = 3'd0;
   logic [15:0] fpr_tags = TAG_WORD_RESET;
   int          kind_count [8];

   // generator view: which registers hold data, so no unwritten one is read
   logic [2:0]  gen_top = 3'd0;
   logic [7:0]  gen_written = 8'd0;

   fpu_instr_type    instr_q [$];
   stack_result_type stack_results_q [$];
   fpu_instr_type    cur_instr;
   stack_result_type got_res;
   stack_result_type want_res;
   logic          instr_taken = 1'b0;
   int            items_accepted = 0;
   int            results_seen = 0;
   int            mismatches = 0;
   int            hold_left = 0;
   logic          hold_done = 1'b0;
   logic          calm;

   assign calm = items_accepted >= CALM_FIRST && items_accepted < CALM_LAST;

   function automatic logic [79:0] to_extended(input logic [31:0] f);
      logic        s;
      logic [7:0]  e;
      logic [22:0] fr;
      int          be;
      s  = f[31];
      e  = f[30:23];
      fr = f[22:0];
      be = int'(e) - 127 + 16383;
      if (e == 8'd0 && fr == 23'd0)
         return {s, 15'd0, 64'd0};
      if (e == 8'hFF)
         return {s, 15'h7FFF, (fr == 23'd0) ? MANT_ONE : {1'b0, fr | 23'h40_0000, 40'd0}};
      // denormals are widened as if normal, bit 63 forced
      return {s, be[14:0], 1'b1, fr, 40'd0};
   endfunction

   function automatic logic [31:0] to_single(input logic [15:0] se, input logic [63:0] mant);
      int be;
      be = int'(se[14:0]);
      if (be == 0 && mant == 64'd0)
         return {se[15], 31'd0};
      be = be - 16383 + 127;
      if (be <= 0)
         return {se[15], 31'd0};
      if (be >= 255)
         return {se[15], 8'hFF, 23'd0};
      return {se[15], be[7:0], mant[62:40]};
   endfunction

   function automatic void push_fpr(input logic [63:0] mant, input logic [15:0] se,
                                    input logic [1:0] tag);
      fpr_top = fpr_top - 3'd1;
      fpr_mant[fpr_top] = mant;
      fpr_se[fpr_top] = se;
      fpr_tags[2 * fpr_top +: 2] = tag;
   endfunction

   function automatic void pop_fpr();
      fpr_tags[2 * fpr_top +: 2] = TAG_EMPTY;
      fpr_top = fpr_top + 3'd1;
   endfunction

   function automatic stack_result_type apply_instruction(input fpu_instr_type ins);
      stack_result_type r;
      logic [79:0]   x;
      logic [2:0]    dst;
      r = '{1'b0, 20'd0, 32'd0, 3'd0, 16'd0};
      kind_count[ins.kind]++;
      case (ins.kind)
         KIND_LOAD: begin
            x = to_extended(ins.load_data);
            push_fpr(x[63:0], x[79:64],
                     (x[63:0] == 64'd0 && x[78:64] == 15'd0) ? TAG_ZERO : TAG_VALID);
         end
         KIND_STORE_POP: begin
            r.store_valid   = 1'b1;
            r.store_address = ins.mem_address;
            r.store_data    = to_single(fpr_se[fpr_top], fpr_mant[fpr_top]);
            pop_fpr();
         end
         KIND_PUSH_ONE:  push_fpr(MANT_ONE, SE_ONE, TAG_VALID);
         KIND_PUSH_ZERO: push_fpr(64'd0, 16'd0, TAG_ZERO);
         KIND_COPY_POP: begin
            dst = fpr_top + ins.reg_index;
            fpr_mant[dst] = fpr_mant[fpr_top];
            fpr_se[dst] = fpr_se[fpr_top];
            fpr_tags[2 * dst +: 2] = fpr_tags[2 * fpr_top +: 2];
            pop_fpr();
         end
         KIND_INIT: begin
            fpr_top  = 3'd0;
            fpr_tags = TAG_WORD_RESET;
         end
         default: ;
      endcase
      r.stack_top = fpr_top;
      r.tag_bits  = fpr_tags;
      return r;
   endfunction

   // reads of a never-written register become a push of zero instead
   task automatic queue_instr(input logic [2:0] kind, input logic [2:0] idx,
                              input logic [31:0] data, input logic [19:0] addr);
      fpu_instr_type ins;
      ins = '{kind, idx, data, addr};
      if ((kind == KIND_STORE_POP || kind == KIND_COPY_POP) && !gen_written[gen_top])
         ins.kind = KIND_PUSH_ZERO;
      case (ins.kind)
         KIND_LOAD, KIND_PUSH_ONE, KIND_PUSH_ZERO: begin
            gen_top = gen_top - 3'd1;
            gen_written[gen_top] = 1'b1;
         end
         KIND_STORE_POP: gen_top = gen_top + 3'd1;
         KIND_COPY_POP: begin
            gen_written[gen_top + idx] = 1'b1;
            gen_top = gen_top + 3'd1;
         end
         KIND_INIT: gen_top = 3'd0;
         default: ;
      endcase
      instr_q.push_back(ins);
   endtask

   function automatic logic [31:0] random_float();
      logic        s;
      logic [22:0] fr;
      s  = 1'($urandom_range(1));
      fr = 23'($urandom_range(23'h7F_FFFF, 1));
      case ($urandom_range(9))
         0: return {s, 31'd0};
         1: return {s, 8'hFF, 23'd0};
         2: return {s, 8'hFF, fr};
         3: return {s, 8'h00, fr};
         4: return {s, $urandom_range(1) ? 8'hFE : 8'h01, fr};
         default: return $urandom();
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   // driver: note acceptance at the rising edge, offer the next item at the falling edge
   always @(posedge clock) begin
      instr_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         instr_taken = 1'b1;
         stack_results_q.push_back(apply_instruction(cur_instr));
         items_accepted++;
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || instr_taken)) begin
         if (instr_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            cur_instr = instr_q.pop_front();
            req_valid       <= 1'b1;
            req_kind        <= cur_instr.kind;
            req_reg_index   <= cur_instr.reg_index;
            req_load_data   <= cur_instr.load_data;
            req_mem_address <= cur_instr.mem_address;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, one long hold-off so the block backs up
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         got_res = '{rsp_store_valid, rsp_store_address, rsp_store_data,
                     rsp_stack_top, rsp_tag_bits};
         if (stack_results_q.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected result item, expected none, got top %0d tags 0x%h",
                     $time, got_res.stack_top, got_res.tag_bits);
         end else begin
            want_res = stack_results_q.pop_front();
            check_field("store_valid", 32'(want_res.store_valid), 32'(got_res.store_valid));
            check_field("store_address", 32'(want_res.store_address),
                        32'(got_res.store_address));
            check_field("store_data", want_res.store_data, got_res.store_data);
            check_field("stack_top", 32'(want_res.stack_top), 32'(got_res.stack_top));
            check_field("tag_bits", 32'(want_res.tag_bits), 32'(got_res.tag_bits));
         end
      end
   end

   initial begin
      #4_000_000;
      $display("x87_register_stack_subset_top test failed");
      $finish;
   end

   initial begin
      int          n;
      int          pick;
      int          guard;
      logic [2:0]  kind;

      // fill the stack with every value class, then read it back
      queue_instr(KIND_PUSH_ZERO, 3'd0, 32'd0, 20'd0);
      queue_instr(KIND_PUSH_ONE, 3'd0, 32'd0, 20'd0);
      queue_instr(KIND_LOAD, 3'd0, 32'h0000_0000, 20'h00001);
      queue_instr(KIND_LOAD, 3'd0, 32'h8000_0000, 20'h00002);
      queue_instr(KIND_LOAD, 3'd0, 32'h7F80_0000, 20'h00004);
      queue_instr(KIND_LOAD, 3'd0, 32'hFF80_0000, 20'h00008);
      queue_instr(KIND_LOAD, 3'd0, 32'h7FC0_0001, 20'h00010);
      queue_instr(KIND_LOAD, 3'd0, 32'h0000_0001, 20'h00020);
      queue_instr(KIND_LOAD, 3'd0, 32'h7F7F_FFFF, 20'h00040);
      queue_instr(KIND_LOAD, 3'd0, 32'h0080_0000, 20'h00080);
      queue_instr(KIND_STORE_POP, 3'd0, 32'd0, 20'h00000);
      queue_instr(KIND_STORE_POP, 3'd0, 32'd0, 20'hFFFFF);
      queue_instr(KIND_STORE_POP, 3'd0, 32'd0, 20'h55555);
      queue_instr(KIND_STORE_POP, 3'd0, 32'd0, 20'hAAAAA);
      // copy onto itself leaves the top empty
      queue_instr(KIND_COPY_POP, 3'd0, 32'd0, 20'd0);
      queue_instr(KIND_COPY_POP, 3'd7, 32'd0, 20'd0);
      queue_instr(KIND_COPY_POP, 3'd3, 32'd0, 20'd0);
      queue_instr(KIND_RSVD_6, 3'd5, 32'hFFFF_FFFF, 20'hFFFFF);
      queue_instr(KIND_RSVD_7, 3'd2, 32'h1234_5678, 20'h12345);
      // init keeps register contents, so a store right after reads old data
      queue_instr(KIND_INIT, 3'd0, 32'd0, 20'd0);
      queue_instr(KIND_STORE_POP, 3'd0, 32'd0, 20'h0F0F0);
      queue_instr(KIND_LOAD, 3'd7, 32'hFFFF_FFFF, 20'hFFFFF);
      queue_instr(KIND_STORE_POP, 3'd0, 32'd0, 20'hFFFFF);
      queue_instr(KIND_PUSH_ONE, 3'd0, 32'd0, 20'd0);
      queue_instr(KIND_STORE_POP, 3'd0, 32'd0, 20'h00000);

      n = 0;
      while (n < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 30)      kind = KIND_LOAD;
         else if (pick < 55) kind = KIND_STORE_POP;
         else if (pick < 62) kind = KIND_PUSH_ONE;
         else if (pick < 68) kind = KIND_PUSH_ZERO;
         else if (pick < 90) kind = KIND_COPY_POP;
         else if (pick < 94) kind = KIND_INIT;
         else                kind = $urandom_range(1) ? KIND_RSVD_6 : KIND_RSVD_7;
         queue_instr(kind, 3'($urandom_range(7)), random_float(),
                     20'($urandom_range(20'hFFFFF)));
         if (kind != KIND_RSVD_6 && kind != KIND_RSVD_7)
            n++;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (instr_q.size() != 0 || req_valid)
         @(posedge clock);
      guard = 0;
      while (stack_results_q.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (stack_results_q.size() != 0) begin
         mismatches += stack_results_q.size();
         $display("%0t ns: %0d result items never arrived", $time, stack_results_q.size());
      end
      repeat (20) @(posedge clock);

      $display("ran %0d instructions (%0d loads, %0d stores, %0d pushes, %0d copies, %0d inits,",
               items_accepted, kind_count[KIND_LOAD], kind_count[KIND_STORE_POP],
               kind_count[KIND_PUSH_ONE] + kind_count[KIND_PUSH_ZERO],
               kind_count[KIND_COPY_POP], kind_count[KIND_INIT]);
      $display("  %0d reserved kinds); %0d result items checked, %0d mismatches",
               kind_count[KIND_RSVD_6] + kind_count[KIND_RSVD_7], results_seen, mismatches);
      if (mismatches == 0)
         $display("x87_register_stack_subset_top test passed");
      else
         $display("x87_register_stack_subset_top test failed");
      $finish;
   end

endmodule
